[hw/rtl/rrs_pkg.sv]
// Shared types and constants of the round-robin scheduler.
package rrs_pkg;

    // Field widths of the input and result beats
    localparam int unsigned ID_W     = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CPU_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLICE_W  = 8;

    // Input opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_RAN      = 3'd2,
        ST_FINISHED = 3'd3,
        ST_IDLE_ADV = 3'd4,
        ST_ALL_DONE = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_CHK,
        S_CHOOSE,
        S_RUN,
        S_FIN,
        S_RESP
    } t_state;

endpackage

[hw/rtl/rrs_if.sv]
// Valid/ready channel interfaces for the scheduler's input and result beats.
interface rrs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [rrs_pkg::ID_W-1:0]     process_id;
    logic [rrs_pkg::TIME_W-1:0]   arrival_time;
    logic [rrs_pkg::CPU_W-1:0]    cpu_time;

    modport source (output valid, opcode, process_id, arrival_time, cpu_time, input ready);
    modport sink   (input valid, opcode, process_id, arrival_time, cpu_time, output ready);
endinterface

interface rrs_out_if;
    logic                         valid;
    logic                         ready;
    logic [rrs_pkg::STATUS_W-1:0] status;
    logic [rrs_pkg::ID_W-1:0]     run_id;
    logic [rrs_pkg::TIME_W-1:0]   clock_now;
    logic [rrs_pkg::CPU_W-1:0]    time_left;
    logic [rrs_pkg::TIME_W-1:0]   wait_total;

    modport source (output valid, status, run_id, clock_now, time_left, wait_total,
                    input ready);
    modport sink   (input valid, status, run_id, clock_now, time_left, wait_total,
                    output ready);
endinterface

[hw/rtl/rrs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module rrs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/round_robin_scheduler_top.sv]
// Top level of the round-robin scheduler: sequencer, queue pointers and result register.
// Round-robin scheduler with a programmable time quantum (i_cfg_data, 0 acts as 1).
// Arrival beats queue a process in the pending FIFO; step beats move arrived processes
// into the ready FIFO, run the ready head for one quantum and report; with none ready
// they advance the clock to the next pending arrival or report all done. Both FIFOs
// live in RAM, DEPTH entries each, and need no clearing after reset. One beat is in
// work at a time: an arrival goes from S_IDLE straight to S_RESP; a step passes S_MV_RD,
// S_CHOOSE and S_RESP, with S_RUN when a process runs a quantum and S_FIN too when it
// finishes, plus a read of the pending RAM and a compare of its arrival time against the
// clock for every pending process it moves, and one more of each when it stops at a head not yet arrived.
// The input is ready again in the cycle after the result is loaded into the output
// register, which holds it until the sink takes it; a result that finds the register
// still occupied waits in the sequencer for as long as the sink stalls.
module round_robin_scheduler_top #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rrs_in_if.sink                       i_in,
    rrs_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [rrs_pkg::SLICE_W-1:0]  i_cfg_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned TW = rrs_pkg::TIME_W;
    localparam int unsigned PW = rrs_pkg::TIME_W + rrs_pkg::CPU_W + rrs_pkg::ID_W;
    localparam int unsigned RW = rrs_pkg::ID_W + rrs_pkg::CPU_W + rrs_pkg::TIME_W;

    // Ring index wrap: a sum below twice the depth folds back with one subtract
    function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] a);
        logic [SW-1:0] d;
        d = a - SW'(DEPTH);
        if (a >= SW'(DEPTH)) begin
            wrap_idx = d[AW-1:0];
        end else begin
            wrap_idx = a[AW-1:0];
        end
    endfunction

    rrs_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_phead, n_phead;
    logic [CW-1:0]    r_pcount, n_pcount;
    logic [AW-1:0]    r_rhead, n_rhead;
    logic [CW-1:0]    r_rcount, n_rcount;
    logic [TW-1:0]    r_clock, n_clock;
    logic [rrs_pkg::SLICE_W-1:0] r_slice, n_slice;
    logic [TW-1:0]    r_parr, n_parr;
    logic [TW-1:0]    r_due, n_due;

    rrs_pkg::t_status             r_res_status, n_res_status;
    logic [rrs_pkg::ID_W-1:0]     r_res_id, n_res_id;
    logic [rrs_pkg::CPU_W-1:0]    r_res_left, n_res_left;
    logic [TW-1:0]                r_res_wait, n_res_wait;

    logic                         r_out_valid, n_out_valid;
    logic [rrs_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [rrs_pkg::ID_W-1:0]     r_out_id, n_out_id;
    logic [TW-1:0]                r_out_clock, n_out_clock;
    logic [rrs_pkg::CPU_W-1:0]    r_out_left, n_out_left;
    logic [TW-1:0]                r_out_wait, n_out_wait;

    // RAM ports
    logic          p_we, p_re, q_we, q_re;
    logic [AW-1:0] p_waddr, p_raddr, q_waddr, q_raddr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic [RW-1:0] q_wdata, q_rdata;

    // Fields of the RAM read words
    logic [TW-1:0]              pend_arr;
    logic [rrs_pkg::CPU_W-1:0]  pend_cpu;
    logic [rrs_pkg::ID_W-1:0]   pend_id;
    logic [rrs_pkg::ID_W-1:0]   rdy_id;
    logic [rrs_pkg::CPU_W-1:0]  rdy_left;
    logic [TW-1:0]              rdy_due;
    logic [rrs_pkg::SLICE_W-1:0] quantum;
    logic                        full;
    logic                        in_acc;

    assign pend_arr = p_rdata[PW-1 -: TW];
    assign pend_cpu = p_rdata[rrs_pkg::CPU_W+rrs_pkg::ID_W-1 -: rrs_pkg::CPU_W];
    assign pend_id  = p_rdata[rrs_pkg::ID_W-1:0];
    assign rdy_id   = q_rdata[RW-1 -: rrs_pkg::ID_W];
    assign rdy_left = q_rdata[rrs_pkg::CPU_W+TW-1 -: rrs_pkg::CPU_W];
    assign rdy_due  = q_rdata[TW-1:0];

    assign quantum = (r_slice == '0) ? rrs_pkg::SLICE_W'(1) : r_slice;
    assign full    = (SW'(r_pcount) + SW'(r_rcount)) >= SW'(DEPTH);
    assign in_acc  = i_in.valid && i_in.ready;

    assign i_in.ready   = (r_state == rrs_pkg::S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.run_id     = r_out_id;
    assign o_out.clock_now  = r_out_clock;
    assign o_out.time_left  = r_out_left;
    assign o_out.wait_total = r_out_wait;

    // Pending FIFO storage: {arrival, cpu, id}
    rrs_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // Ready FIFO storage: {id, remaining, arrival + cpu}
    rrs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrs_pkg::S_IDLE;
            r_phead     <= '0;
            r_pcount    <= '0;
            r_rhead     <= '0;
            r_rcount    <= '0;
            r_clock     <= '0;
            r_slice     <= rrs_pkg::SLICE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phead     <= n_phead;
            r_pcount    <= n_pcount;
            r_rhead     <= n_rhead;
            r_rcount    <= n_rcount;
            r_clock     <= n_clock;
            r_slice     <= n_slice;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_parr       <= n_parr;
        r_due        <= n_due;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_left   <= n_res_left;
        r_res_wait   <= n_res_wait;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_clock  <= n_out_clock;
        r_out_left   <= n_out_left;
        r_out_wait   <= n_out_wait;
    end

    // Sequencer: next state, queue updates and RAM control
    always_comb begin
        n_state      = r_state;
        n_phead      = r_phead;
        n_pcount     = r_pcount;
        n_rhead      = r_rhead;
        n_rcount     = r_rcount;
        n_clock      = r_clock;
        n_slice      = i_cfg_we ? i_cfg_data : r_slice;
        n_parr       = r_parr;
        n_due        = r_due;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_left   = r_res_left;
        n_res_wait   = r_res_wait;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_clock  = r_out_clock;
        n_out_left   = r_out_left;
        n_out_wait   = r_out_wait;

        p_we    = 1'b0;
        p_waddr = wrap_idx(SW'(r_phead) + SW'(r_pcount));
        p_wdata = {i_in.arrival_time, i_in.cpu_time, i_in.process_id};
        p_re    = 1'b0;
        p_raddr = r_phead;
        q_we    = 1'b0;
        q_waddr = wrap_idx(SW'(r_rhead) + SW'(r_rcount));
        q_wdata = {pend_id, pend_cpu, pend_arr + TW'(pend_cpu)};
        q_re    = 1'b0;
        q_raddr = r_rhead;

        unique case (r_state)
            rrs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_res_id   = '0;
                    n_res_left = '0;
                    n_res_wait = '0;
                    if (i_in.opcode == rrs_pkg::OP_STEP) begin
                        n_state = rrs_pkg::S_MV_RD;
                    end else begin
                        n_state = rrs_pkg::S_RESP;
                        if (full) begin
                            n_res_status = rrs_pkg::ST_REJECTED;
                        end else begin
                            p_we         = 1'b1;
                            n_pcount     = r_pcount + 1'b1;
                            n_res_status = rrs_pkg::ST_ACCEPTED;
                        end
                    end
                end
            end
            // Fetch the pending head
            rrs_pkg::S_MV_RD: begin
                if (r_pcount == '0) begin
                    n_state = rrs_pkg::S_CHOOSE;
                end else begin
                    p_re    = 1'b1;
                    n_state = rrs_pkg::S_MV_CHK;
                end
            end
            // Move the head to the ready FIFO if it has arrived
            rrs_pkg::S_MV_CHK: begin
                if (r_clock < pend_arr) begin
                    n_parr  = pend_arr;
                    n_state = rrs_pkg::S_CHOOSE;
                end else begin
                    n_phead  = wrap_idx(SW'(r_phead) + SW'(1));
                    n_pcount = r_pcount - 1'b1;
                    if (r_rcount < CW'(DEPTH)) begin
                        q_we     = 1'b1;
                        n_rcount = r_rcount + 1'b1;
                    end
                    n_state = rrs_pkg::S_MV_RD;
                end
            end
            rrs_pkg::S_CHOOSE: begin
                n_state = rrs_pkg::S_RESP;
                if (r_rcount != '0) begin
                    q_re    = 1'b1;
                    n_state = rrs_pkg::S_RUN;
                end else if (r_pcount != '0) begin
                    n_clock      = r_parr;
                    n_res_status = rrs_pkg::ST_IDLE_ADV;
                end else begin
                    n_res_status = rrs_pkg::ST_ALL_DONE;
                end
            end
            // Run the ready head for one quantum; pop and requeue share one cycle
            rrs_pkg::S_RUN: begin
                n_rhead  = wrap_idx(SW'(r_rhead) + SW'(1));
                n_res_id = rdy_id;
                q_wdata  = {rdy_id, rdy_left - rrs_pkg::CPU_W'(quantum), rdy_due};
                if (rdy_left > rrs_pkg::CPU_W'(quantum)) begin
                    q_we         = 1'b1;
                    n_clock      = r_clock + TW'(quantum);
                    n_res_status = rrs_pkg::ST_RAN;
                    n_res_left   = rdy_left - rrs_pkg::CPU_W'(quantum);
                    n_state      = rrs_pkg::S_RESP;
                end else begin
                    n_rcount     = r_rcount - 1'b1;
                    n_clock      = r_clock + TW'(rdy_left);
                    n_due        = rdy_due;
                    n_res_status = rrs_pkg::ST_FINISHED;
                    n_res_left   = '0;
                    n_state      = rrs_pkg::S_FIN;
                end
            end
            // Wait of the finished process
            rrs_pkg::S_FIN: begin
                n_res_wait = r_clock - r_due;
                n_state    = rrs_pkg::S_RESP;
            end
            // Hand the result to the output register once it is free
            rrs_pkg::S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_clock  = r_clock;
                    n_out_left   = r_res_left;
                    n_out_wait   = r_res_wait;
                    n_state      = rrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrs_pkg::S_IDLE;
            end
        endcase
    end

    // Held processes never exceed the depth
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_pcount) + SW'(r_rcount)) <= SW'(DEPTH))
        else $error("pending plus ready count exceeds depth");

    // An accepted arrival grows the pending FIFO by one
    a_arrive_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.opcode == rrs_pkg::OP_ARRIVE && !full)
        |=> r_pcount == $past(r_pcount) + 1'b1)
        else $error("arrival not pushed");

    // A quantum runs only with a ready process
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rrs_pkg::S_RUN |-> r_rcount != '0)
        else $error("run with empty ready FIFO");

    // A finished process reports no remaining time
    a_fin_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == rrs_pkg::ST_FINISHED) |-> r_out_left == '0)
        else $error("finished beat with time left");

    // An accepted input always puts a beat in work
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != rrs_pkg::S_IDLE)
        else $error("sequencer stayed idle after accept");
endmodule
